FILE: hw/rtl/ufifo_pkg.sv
// ----------------------------------------------------------------------------
// ufifo_pkg
// Types, codes and pointer helpers shared by the UART buffer with CTS/RTS.
// ----------------------------------------------------------------------------
`default_nettype none

package ufifo_pkg;

    localparam int TX_DEPTH = 64;
    localparam int RX_DEPTH = 64;
    localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    // occupancy width: wide enough for the pointers and for the 6-bit marks
    localparam int RX_CW    = (RX_AW > 6) ? RX_AW : 6;

    // request codes
    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_READ   = 3'd1;
    localparam logic [2:0] REQ_PEEK   = 3'd2;
    localparam logic [2:0] REQ_COUNT  = 3'd3;
    localparam logic [2:0] REQ_RX     = 3'd4;
    localparam logic [2:0] REQ_TXRDY  = 3'd5;
    localparam logic [2:0] REQ_CTS    = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CTS_EN = 2'd0;
    localparam logic [1:0] CFG_RTS_EN = 2'd1;
    localparam logic [1:0] CFG_HI     = 2'd2;
    localparam logic [1:0] CFG_LO     = 2'd3;

    localparam logic [5:0] HI_RESET   = 6'd48;
    localparam logic [5:0] LO_RESET   = 6'd16;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_in;
        logic       tx_idle;
        logic       cts_level;
    } t_ufifo_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic [5:0] rx_count;
        logic [1:0] status;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rts_out;
        logic       send_paused_out;
    } t_ufifo_rsp;

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/uart_fifo_cts_rts_flow_control.sv
// ----------------------------------------------------------------------------
// uart_fifo_cts_rts_flow_control
// Transmit and receive ring buffers of a UART with CTS/RTS flow control.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready / i_in) carries host accesses
//   (write, read, peek, count query) and line events (rx byte, transmitter
//   ready, CTS change). Every request beat yields exactly one response beat
//   on o_out_valid / i_out_ready / o_out.
//   Configuration beats (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data)
//   are always taken and must only be sent while the block is idle.
//   Path: a request beat loads the input register, and the request then
//   passes to the response register, which drives o_out_valid. Throughput: one
//   request per cycle while the response is not held, set by the single
//   input-to-response pass; both buffers read their tail entry into a
//   registered read port every cycle, so requests never wait on them.
//   Stall: while the response is held, the request in the input register
//   waits and o_in_ready drops only once that register is occupied too.
//   Reset clears the pointers, the flow-control flags and the registers
//   (marks 48 / 16); buffer contents are left as they were.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_fifo_cts_rts_flow_control (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire ufifo_pkg::t_ufifo_req i_in,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output ufifo_pkg::t_ufifo_rsp  o_out,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [1:0]             i_cfg_index,
    input  wire  [5:0]             i_cfg_data
);

    localparam int TX_AW = ufifo_pkg::TX_AW;
    localparam int RX_AW = ufifo_pkg::RX_AW;
    localparam int RX_CW = ufifo_pkg::RX_CW;

    // configuration
    logic       r_cts_en;
    logic       r_rts_en;
    logic [5:0] r_hi;
    logic [5:0] r_lo;

    // control state
    logic [TX_AW-1:0] r_tx_head, r_tx_tail, n_tx_head, n_tx_tail;
    logic [RX_AW-1:0] r_rx_head, r_rx_tail, n_rx_head, n_rx_tail;
    logic             r_cts_stop, n_cts_stop;
    logic             r_send_paused, n_send_paused;
    logic             r_recv_paused, n_recv_paused;
    logic             r_irq_on, n_irq_on;

    // buffers and their registered tail read ports
    logic [7:0] r_tx_mem [ufifo_pkg::TX_DEPTH];
    logic [7:0] r_rx_mem [ufifo_pkg::RX_DEPTH];
    logic [7:0] r_tx_rd;
    logic [7:0] r_rx_rd;
    logic       tx_we, rx_we;

    // pipeline
    logic                  r_in_vld;
    ufifo_pkg::t_ufifo_req r_in;
    logic                  r_out_vld;
    ufifo_pkg::t_ufifo_rsp r_out, n_out;
    logic                  advance;

    logic [RX_CW-1:0] occ;
    logic             tx_empty, rx_empty;
    logic [TX_AW-1:0] tx_nxt, tx_tail_inc;
    logic [RX_AW-1:0] rx_nxt, rx_tail_inc;
    logic [TX_AW-1:0] tx_rd_addr;
    logic [RX_AW-1:0] rx_rd_addr;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign tx_empty    = (r_tx_head == r_tx_tail);
    assign rx_empty    = (r_rx_head == r_rx_tail);
    assign tx_nxt      = ufifo_pkg::tx_inc(r_tx_head);
    assign rx_nxt      = ufifo_pkg::rx_inc(r_rx_head);
    assign tx_tail_inc = ufifo_pkg::tx_inc(r_tx_tail);
    assign rx_tail_inc = ufifo_pkg::rx_inc(r_rx_tail);

    // modular occupancy; the wrap term vanishes when the width is exact
    assign occ = RX_CW'(r_rx_head) - RX_CW'(r_rx_tail)
               + ((r_rx_head < r_rx_tail) ? RX_CW'(ufifo_pkg::RX_DEPTH) : '0);

    always_comb begin
        logic rts_chk;
        n_tx_head     = r_tx_head;
        n_tx_tail     = r_tx_tail;
        n_rx_head     = r_rx_head;
        n_rx_tail     = r_rx_tail;
        n_cts_stop    = r_cts_stop;
        n_send_paused = r_send_paused;
        n_recv_paused = r_recv_paused;
        n_irq_on      = r_irq_on;
        tx_we         = 1'b0;
        rx_we         = 1'b0;
        rts_chk       = 1'b0;
        n_out         = '0;
        n_out.rx_count = occ[5:0];
        n_out.status   = ufifo_pkg::ST_OK;

        case (r_in.req_type)
            ufifo_pkg::REQ_WRITE: begin
                if (tx_empty && r_in.tx_idle && !r_cts_stop) begin
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = r_in.data_in;
                end else if (tx_nxt == r_tx_tail) begin
                    n_out.status = ufifo_pkg::ST_FULL;
                end else begin
                    tx_we     = 1'b1;
                    n_tx_head = tx_nxt;
                    if (!r_send_paused) begin
                        n_irq_on = 1'b1;
                    end
                end
            end
            ufifo_pkg::REQ_READ, ufifo_pkg::REQ_PEEK: begin
                if (rx_empty) begin
                    n_out.status = ufifo_pkg::ST_EMPTY;
                end else begin
                    rts_chk         = 1'b1;
                    n_out.read_data = r_rx_rd;
                    if (r_in.req_type == ufifo_pkg::REQ_READ) begin
                        n_rx_tail = rx_tail_inc;
                    end
                end
            end
            ufifo_pkg::REQ_COUNT: begin
                rts_chk = 1'b1;
            end
            ufifo_pkg::REQ_RX: begin
                if (rx_nxt == r_rx_tail) begin
                    n_out.status = ufifo_pkg::ST_FULL;
                end else begin
                    rx_we     = 1'b1;
                    n_rx_head = rx_nxt;
                end
            end
            ufifo_pkg::REQ_TXRDY: begin
                if (r_irq_on) begin
                    if (r_cts_stop) begin
                        if (!r_send_paused) begin
                            n_irq_on      = 1'b0;
                            n_send_paused = 1'b1;
                        end
                    end else if (tx_empty) begin
                        n_irq_on = 1'b0;
                    end else begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = r_tx_rd;
                        n_tx_tail      = tx_tail_inc;
                        if (tx_tail_inc == r_tx_head) begin
                            n_irq_on = 1'b0;
                        end
                    end
                end
            end
            ufifo_pkg::REQ_CTS: begin
                if (!r_cts_en) begin
                    n_cts_stop = 1'b0;
                end else begin
                    n_cts_stop = r_in.cts_level;
                    if (!r_in.cts_level && r_send_paused) begin
                        n_send_paused = 1'b0;
                        n_irq_on      = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // RTS hysteresis on occupancy before the access
        if (rts_chk && r_rts_en) begin
            if (!r_recv_paused && occ >= RX_CW'(r_hi)) begin
                n_recv_paused = 1'b1;
            end else if (r_recv_paused && occ <= RX_CW'(r_lo)) begin
                n_recv_paused = 1'b0;
            end
        end

        n_out.rts_out         = n_recv_paused && r_rts_en;
        n_out.send_paused_out = n_send_paused;

        // hold everything when no request moves forward
        if (!advance) begin
            n_tx_head     = r_tx_head;
            n_tx_tail     = r_tx_tail;
            n_rx_head     = r_rx_head;
            n_rx_tail     = r_rx_tail;
            n_cts_stop    = r_cts_stop;
            n_send_paused = r_send_paused;
            n_recv_paused = r_recv_paused;
            n_irq_on      = r_irq_on;
            tx_we         = 1'b0;
            rx_we         = 1'b0;
        end
    end

    assign tx_rd_addr = i_rst_n ? n_tx_tail : '0;
    assign rx_rd_addr = i_rst_n ? n_rx_tail : '0;

    // buffers: write at head, read the next tail with write forwarding
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[r_tx_head] <= r_in.data_in;
        end
        if (tx_we && (r_tx_head == tx_rd_addr)) begin
            r_tx_rd <= r_in.data_in;
        end else begin
            r_tx_rd <= r_tx_mem[tx_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[r_rx_head] <= r_in.data_in;
        end
        if (rx_we && (r_rx_head == rx_rd_addr)) begin
            r_rx_rd <= r_in.data_in;
        end else begin
            r_rx_rd <= r_rx_mem[rx_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head     <= '0;
            r_tx_tail     <= '0;
            r_rx_head     <= '0;
            r_rx_tail     <= '0;
            r_cts_stop    <= 1'b0;
            r_send_paused <= 1'b0;
            r_recv_paused <= 1'b0;
            r_irq_on      <= 1'b0;
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_tx_head     <= n_tx_head;
            r_tx_tail     <= n_tx_tail;
            r_rx_head     <= n_rx_head;
            r_rx_tail     <= n_rx_tail;
            r_cts_stop    <= n_cts_stop;
            r_send_paused <= n_send_paused;
            r_recv_paused <= n_recv_paused;
            r_irq_on      <= n_irq_on;
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cts_en <= 1'b0;
            r_rts_en <= 1'b0;
            r_hi     <= ufifo_pkg::HI_RESET;
            r_lo     <= ufifo_pkg::LO_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ufifo_pkg::CFG_CTS_EN: r_cts_en <= i_cfg_data[0];
                ufifo_pkg::CFG_RTS_EN: r_rts_en <= i_cfg_data[0];
                ufifo_pkg::CFG_HI:     r_hi     <= i_cfg_data;
                ufifo_pkg::CFG_LO:     r_lo     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a byte handed to the transmitter never carries an error status
    a_txv_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out.tx_valid || (r_out.status == ufifo_pkg::ST_OK)))
        else $error("tx_valid with non-ok status");

    // pointers move only when a request passes through
    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_rx_head) && $stable(r_rx_tail)
                      && $stable(r_tx_head) && $stable(r_tx_tail)))
        else $error("pointer moved without a request");

    // a stalled request stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_in)))
        else $error("held request lost");

endmodule

`default_nettype wire

FILE: test/ufifo_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ufifo_checker
// Watches the request, configuration and response channels of the UART
// buffer, predicts each response beat from its own copy of the buffers and
// flow-control flags, and compares every response field by field.
// ----------------------------------------------------------------------------
module ufifo_checker (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_in_ready,
    input  ufifo_pkg::t_ufifo_req i_in,
    input  wire                   i_out_valid,
    input  wire                   i_out_ready,
    input  ufifo_pkg::t_ufifo_rsp i_out,
    input  wire                   i_cfg_valid,
    input  wire                   i_cfg_ready,
    input  wire [1:0]             i_cfg_index,
    input  wire [5:0]             i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [7:0] txq_mem [ufifo_pkg::TX_DEPTH];
    logic [7:0] rxq_mem [ufifo_pkg::RX_DEPTH];
    int         txq_wr, txq_rd;
    int         rxq_wr, rxq_rd;
    bit         stop_seen, tx_held, rx_throttled, tx_armed;
    bit         cts_on, rts_on;
    logic [5:0] hi_mark, lo_mark;
    ufifo_pkg::t_ufifo_rsp rsp_due [$];
    int         errs = 0;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errs++;
    endtask

    function automatic int rx_fill();
        return (ufifo_pkg::RX_DEPTH + rxq_wr - rxq_rd) % ufifo_pkg::RX_DEPTH;
    endfunction

    // RTS hysteresis on receive occupancy; flag frozen while RTS is unused
    function automatic void throttle_rx();
        int fill;
        fill = rx_fill();
        if (rts_on) begin
            if (!rx_throttled && fill >= hi_mark)
                rx_throttled = 1'b1;
            else if (rx_throttled && fill <= lo_mark)
                rx_throttled = 1'b0;
        end
    endfunction

    function automatic ufifo_pkg::t_ufifo_rsp predict_rsp(input ufifo_pkg::t_ufifo_req r);
        ufifo_pkg::t_ufifo_rsp e;
        int                    nxt;
        e = '0;
        e.rx_count = 6'(rx_fill());
        case (r.req_type)
            ufifo_pkg::REQ_WRITE: begin
                if (txq_wr == txq_rd && r.tx_idle && !stop_seen) begin
                    e.tx_valid = 1'b1;
                    e.tx_byte  = r.data_in;
                end else begin
                    nxt = (txq_wr + 1) % ufifo_pkg::TX_DEPTH;
                    if (nxt == txq_rd) begin
                        e.status = ufifo_pkg::ST_FULL;
                    end else begin
                        txq_mem[txq_wr] = r.data_in;
                        txq_wr = nxt;
                        if (!tx_held)
                            tx_armed = 1'b1;
                    end
                end
            end
            ufifo_pkg::REQ_READ, ufifo_pkg::REQ_PEEK: begin
                if (rxq_wr == rxq_rd) begin
                    e.status = ufifo_pkg::ST_EMPTY;
                end else begin
                    throttle_rx();
                    e.read_data = rxq_mem[rxq_rd];
                    if (r.req_type == ufifo_pkg::REQ_READ)
                        rxq_rd = (rxq_rd + 1) % ufifo_pkg::RX_DEPTH;
                end
            end
            ufifo_pkg::REQ_COUNT: begin
                throttle_rx();
            end
            ufifo_pkg::REQ_RX: begin
                nxt = (rxq_wr + 1) % ufifo_pkg::RX_DEPTH;
                if (nxt == rxq_rd) begin
                    e.status = ufifo_pkg::ST_FULL;
                end else begin
                    rxq_mem[rxq_wr] = r.data_in;
                    rxq_wr = nxt;
                end
            end
            ufifo_pkg::REQ_TXRDY: begin
                if (tx_armed) begin
                    if (stop_seen) begin
                        if (!tx_held) begin
                            tx_armed = 1'b0;
                            tx_held  = 1'b1;
                        end
                    end else if (txq_wr == txq_rd) begin
                        tx_armed = 1'b0;
                    end else begin
                        e.tx_valid = 1'b1;
                        e.tx_byte  = txq_mem[txq_rd];
                        txq_rd = (txq_rd + 1) % ufifo_pkg::TX_DEPTH;
                        if (txq_wr == txq_rd)
                            tx_armed = 1'b0;
                    end
                end
            end
            ufifo_pkg::REQ_CTS: begin
                if (!cts_on) begin
                    stop_seen = 1'b0;
                end else begin
                    stop_seen = r.cts_level;
                    // resume a paused sender on release
                    if (!stop_seen && tx_held) begin
                        tx_held  = 1'b0;
                        tx_armed = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        e.rts_out         = rx_throttled && rts_on;
        e.send_paused_out = tx_held;
        return e;
    endfunction

    always @(posedge i_clk) begin : watch
        ufifo_pkg::t_ufifo_rsp want;
        if (!i_rst_n) begin
            txq_wr       = 0;
            txq_rd       = 0;
            rxq_wr       = 0;
            rxq_rd       = 0;
            stop_seen    = 1'b0;
            tx_held      = 1'b0;
            rx_throttled = 1'b0;
            tx_armed     = 1'b0;
            cts_on       = 1'b0;
            rts_on       = 1'b0;
            hi_mark      = ufifo_pkg::HI_RESET;
            lo_mark      = ufifo_pkg::LO_RESET;
            rsp_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (rsp_due.size() == 0) begin
                    report_mismatch("response beat with nothing expected",
                                    8'(i_out.status), 8'd0);
                end else begin
                    want = rsp_due.pop_front();
                    if (i_out.read_data !== want.read_data)
                        report_mismatch("read_data", i_out.read_data, want.read_data);
                    if (i_out.rx_count !== want.rx_count)
                        report_mismatch("rx_count", 8'(i_out.rx_count),
                                        8'(want.rx_count));
                    if (i_out.status !== want.status)
                        report_mismatch("status", 8'(i_out.status), 8'(want.status));
                    if (i_out.tx_valid !== want.tx_valid)
                        report_mismatch("tx_valid", 8'(i_out.tx_valid),
                                        8'(want.tx_valid));
                    if (i_out.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", i_out.tx_byte, want.tx_byte);
                    if (i_out.rts_out !== want.rts_out)
                        report_mismatch("rts_out", 8'(i_out.rts_out), 8'(want.rts_out));
                    if (i_out.send_paused_out !== want.send_paused_out)
                        report_mismatch("send_paused_out", 8'(i_out.send_paused_out),
                                        8'(want.send_paused_out));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ufifo_pkg::CFG_CTS_EN: cts_on  = i_cfg_data[0];
                    ufifo_pkg::CFG_RTS_EN: rts_on  = i_cfg_data[0];
                    ufifo_pkg::CFG_HI:     hi_mark = i_cfg_data;
                    ufifo_pkg::CFG_LO:     lo_mark = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                rsp_due.push_back(predict_rsp(i_in));
        end
        o_fail_count <= errs;
        o_pending    <= rsp_due.size();
    end

endmodule

FILE: test/tb_uart_fifo_cts_rts_flow_control.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_fifo_cts_rts_flow_control
// Drives host accesses and line events into the UART buffer under several
// flow-control settings, with random gaps and back-pressure, and reports the
// verdict from the failure count of the checker beside the block.
// ----------------------------------------------------------------------------
module tb_uart_fifo_cts_rts_flow_control;

    localparam int         LIMIT       = 200000;
    localparam int         TAIL        = 8;
    localparam int         HOLD_LEN    = 300;
    localparam int         HOLD_AT     = 20;
    localparam int         PHASE_ITEMS = 235;
    localparam logic [2:0] REQ_NONE    = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    ufifo_pkg::t_ufifo_req in_req    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    ufifo_pkg::t_ufifo_rsp out_rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = ufifo_pkg::CFG_CTS_EN;
    logic [5:0]            cfg_data  = '0;

    int fails;
    int pending;
    int cycles        = 0;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int hold_cnt      = 0;
    bit filling       = 1'b1;
    int seg_left      = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    uart_fifo_cts_rts_flow_control DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ufifo_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_rsp),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    // response side: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt + 1;
            if (hold_cnt == HOLD_LEN - 1)
                hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic ufifo_pkg::t_ufifo_req req_of(input logic [2:0] op,
                                                     input logic [7:0] data,
                                                     input bit idle, input bit level);
        ufifo_pkg::t_ufifo_req r;
        r.req_type  = op;
        r.data_in   = data;
        r.tx_idle   = idle;
        r.cts_level = level;
        return r;
    endfunction

    // fill segments push both buffers toward full, drain segments empty them
    function automatic ufifo_pkg::t_ufifo_req random_req(input bit fill);
        ufifo_pkg::t_ufifo_req r;
        int                    pick;
        r.data_in = 8'($urandom);
        r.tx_idle = 1'($urandom);
        pick      = $urandom_range(99);
        if (fill) begin
            r.cts_level = 1'($urandom);
            r.req_type  = (pick < 30) ? ufifo_pkg::REQ_WRITE :
                          (pick < 70) ? ufifo_pkg::REQ_RX    :
                          (pick < 76) ? ufifo_pkg::REQ_READ  :
                          (pick < 80) ? ufifo_pkg::REQ_PEEK  :
                          (pick < 86) ? ufifo_pkg::REQ_COUNT :
                          (pick < 92) ? ufifo_pkg::REQ_TXRDY :
                          (pick < 98) ? ufifo_pkg::REQ_CTS   : REQ_NONE;
        end else begin
            r.cts_level = ($urandom_range(3) == 0);
            r.req_type  = (pick < 5)  ? ufifo_pkg::REQ_WRITE :
                          (pick < 10) ? ufifo_pkg::REQ_RX    :
                          (pick < 45) ? ufifo_pkg::REQ_READ  :
                          (pick < 50) ? ufifo_pkg::REQ_PEEK  :
                          (pick < 60) ? ufifo_pkg::REQ_COUNT :
                          (pick < 90) ? ufifo_pkg::REQ_TXRDY :
                          (pick < 98) ? ufifo_pkg::REQ_CTS   : REQ_NONE;
        end
        return r;
    endfunction

    // leaves valid high at the accepting edge; the next call keeps or drops it
    task automatic send_req(input ufifo_pkg::t_ufifo_req r);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [1:0] idx, input logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_config(input bit cts, input bit rts, input logic [5:0] hi,
                               input logic [5:0] lo);
        drain();
        cfg_beat(ufifo_pkg::CFG_CTS_EN, {5'd0, cts});
        cfg_beat(ufifo_pkg::CFG_RTS_EN, {5'd0, rts});
        cfg_beat(ufifo_pkg::CFG_HI, hi);
        cfg_beat(ufifo_pkg::CFG_LO, lo);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input bit cts, input bit rts, input logic [5:0] hi,
                             input logic [5:0] lo, input int snd_pct, input int rcv_pct);
        load_config(cts, rts, hi, lo);
        snd_idle_pct = snd_pct;
        rcv_stall_pct <= rcv_pct;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            // hold the response side long enough to back up the request side
            if (k == HOLD_AT)
                hold_req <= 1'b1;
            if (seg_left == 0) begin
                filling  = 1'($urandom_range(1));
                seg_left = $urandom_range(200, 40);
            end
            seg_left--;
            send_req(random_req(filling));
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: CTS and RTS unused
        send_req(req_of(ufifo_pkg::REQ_READ,  8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_PEEK,  8'h00, 1'b0, 1'b0));
        send_req(req_of(REQ_NONE,             8'hFF, 1'b1, 1'b1));
        send_req(req_of(ufifo_pkg::REQ_WRITE, 8'hFF, 1'b1, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_WRITE, 8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_WRITE, 8'hA5, 1'b1, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_TXRDY, 8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_TXRDY, 8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_TXRDY, 8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_CTS,   8'h00, 1'b0, 1'b1));
        send_req(req_of(ufifo_pkg::REQ_RX,    8'hFF, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_PEEK,  8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_READ,  8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_READ,  8'h00, 1'b0, 1'b0));

        // CTS pause and resume, RTS raise and release on small marks
        load_config(1'b1, 1'b1, 6'd2, 6'd0);
        send_req(req_of(ufifo_pkg::REQ_CTS,   8'h00, 1'b0, 1'b1));
        send_req(req_of(ufifo_pkg::REQ_WRITE, 8'h3C, 1'b1, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_TXRDY, 8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_WRITE, 8'hC3, 1'b1, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_CTS,   8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_TXRDY, 8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_TXRDY, 8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_RX,    8'h11, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_RX,    8'h22, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_COUNT, 8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_READ,  8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_READ,  8'h00, 1'b0, 1'b0));
        send_req(req_of(ufifo_pkg::REQ_COUNT, 8'h00, 1'b0, 1'b0));

        run_phase(1'b1, 1'b1, 6'd48, 6'd16, 10, 72);
        run_phase(1'b1, 1'b1, 6'd63, 6'd0,  10, 72);
        run_phase(1'b0, 1'b1, 6'd0,  6'd0,  10, 72);
        run_phase(1'b1, 1'b0, 6'd63, 6'd63, 72, 10);
        run_phase(1'b1, 1'b1, 6'd10, 6'd40, 72, 10);
        run_phase(1'b0, 1'b0, 6'd32, 6'd8,  72, 10);
        run_phase(1'b1, 1'b1, 6'd63, 6'd63, 0,  0);
        run_phase(1'b1, 1'b1, 6'd0,  6'd63, 0,  0);

        drain();
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
